/* sv/psf_pkg.sv */
package psf_pkg;

	localparam int unsigned FILL_W = 5;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TTL = 2'd1;

	localparam logic [7:0] FOOTER_BYTE = 8'hAA;
	localparam logic [7:0] FRAME_OVERHEAD = 8'd9;
	localparam logic [FILL_W-1:0] HDR_BYTES = 5'd6;

	typedef struct packed {
		logic [7:0] header;
		logic [7:0] ack;
		logic [7:0] control;
		logic [7:0] dest;
		logic [7:0] src;
		logic [7:0] len;
		logic [7:0] csum;
		logic [FILL_W-1:0] fill;
		logic last;
	} frame_desc_t;

	typedef struct packed {
		logic en;
		logic bank;
		logic [FILL_W-1:0] off;
		logic [7:0] data;
	} store_wr_t;

endpackage

/* sv/packet_segmenting_framer_core.sv */
// path: the first byte of a frame passes the descriptor queue, stage s1 and the
// output register after the request that completes the frame is taken
// throughput: one frame byte per cycle while popped; per frame, n payload bytes
// give n + 9 bytes; input bytes are taken one per cycle while one of two payload
// banks is free; reset: all control state cleared, version 0, ttl 15; no clearing pass
module packet_segmenting_framer_core import psf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 23,
	parameter int unsigned SEQ_WRAP = 15
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic [7:0] packet_length,
	input logic [7:0] ack_byte,
	output logic empty,
	input logic pop,
	output logic [7:0] frame_byte,
	output logic frame_end,
	output logic packet_end,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	frame_desc_t push_desc;
	frame_desc_t head;
	store_wr_t wr;

	psf_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.SEQ_WRAP(SEQ_WRAP)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.packet_length(packet_length),
		.ack_byte(ack_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.q_push(q_push),
		.q_desc(push_desc),
		.wr(wr)
	);

	psf_desc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_desc(push_desc),
		.full(q_full),
		.pop(q_pop),
		.head(head),
		.empty(q_empty)
	);

	psf_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.head(head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.packet_end(packet_end)
	);

endmodule

/* sv/psf_front.sv */
module psf_front import psf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 23,
	parameter int unsigned SEQ_WRAP = 15
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic [7:0] packet_length,
	input logic [7:0] ack_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic q_full,
	output logic q_push,
	output frame_desc_t q_desc,
	output store_wr_t wr
);

	localparam logic [16:0] RECIP = 17'((65536 + MAX_PAYLOAD - 1) / MAX_PAYLOAD);
	localparam logic [8:0] ROUND_UP = 9'(MAX_PAYLOAD - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PAYLOAD);
	localparam logic [4:0] SEQ_LIMIT = 5'(SEQ_WRAP);

	logic [1:0] version_q;
	logic [3:0] ttl_q;
	logic [7:0] pkt_cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [2:0] fidx_q;
	logic [3:0] seq_q;
	logic [3:0] pseq_q;
	logic [7:0] src_q;
	logic [7:0] dest_q;
	logic [7:0] len_q;
	logic [7:0] ack_q;
	logic [7:0] xor_q;
	logic [2:0] count_q;
	logic bank_q;

	logic start;
	logic accept;
	logic [8:0] total;
	logic [25:0] prod;
	logic [4:0] seq_inc;
	logic [3:0] seq_next;
	logic [FILL_W-1:0] fill_b;
	logic [FILL_W-1:0] fill_n;
	logic [7:0] xor_n;
	logic [7:0] src_n;
	logic [7:0] dest_n;
	logic [7:0] len_b;
	logic [7:0] ack_b;
	logic [3:0] pseq_b;
	logic [2:0] fidx_b;
	logic [2:0] count_b;
	logic [7:0] cnt_n;
	logic [7:0] frame_len;
	logic [7:0] header;
	logic last;
	logic send;

	assign cfg_ready = 1'b1;
	assign full = q_full;
	assign accept = push && !q_full;
	assign start = (pkt_cnt_q == 8'd0);

	always_comb begin
		total = (packet_length == 8'd0) ? 9'd256 : {1'b0, packet_length};
		prod = {17'd0, total + ROUND_UP} * {9'd0, RECIP};
		seq_inc = {1'b0, seq_q} + 5'd1;
		seq_next = (seq_inc >= SEQ_LIMIT) ? 4'd0 : seq_inc[3:0];

		fill_b = start ? '0 : fill_q;
		len_b = start ? packet_length : len_q;
		ack_b = start ? ack_byte : ack_q;
		pseq_b = start ? seq_q : pseq_q;
		fidx_b = start ? 3'd0 : fidx_q;
		count_b = start ? prod[18:16] : count_q;
		src_n = (pkt_cnt_q == 8'd2) ? data_byte : (start ? 8'd0 : src_q);
		dest_n = (pkt_cnt_q == 8'd3) ? data_byte : (start ? 8'd0 : dest_q);
		xor_n = (start ? 8'd0 : xor_q) ^ data_byte;

		fill_n = fill_b + FILL_W'(1);
		cnt_n = pkt_cnt_q + 8'd1;
		last = (cnt_n == len_b);
		send = last || (fill_n == FILL_MAX);

		frame_len = {{(8 - FILL_W){1'b0}}, fill_n} + FRAME_OVERHEAD;
		header = {version_q, fidx_b, count_b};
	end

	assign q_push = accept && send;

	always_comb begin
		q_desc.header = header;
		q_desc.ack = ack_b;
		q_desc.control = {ttl_q, pseq_b};
		q_desc.dest = dest_n;
		q_desc.src = src_n;
		q_desc.len = frame_len;
		q_desc.csum = header ^ src_n ^ dest_n ^ frame_len ^ FOOTER_BYTE ^ xor_n;
		q_desc.fill = fill_n;
		q_desc.last = last;
		wr.en = accept;
		wr.bank = bank_q;
		wr.off = fill_b;
		wr.data = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 2'd0;
			ttl_q <= 4'd15;
			pkt_cnt_q <= '0;
			fill_q <= '0;
			fidx_q <= '0;
			seq_q <= '0;
			pseq_q <= '0;
			src_q <= '0;
			dest_q <= '0;
			len_q <= '0;
			ack_q <= '0;
			xor_q <= '0;
			count_q <= '0;
			bank_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_VERSION) begin
					version_q <= cfg_data[1:0];
				end else if (cfg_index == REG_TTL) begin
					ttl_q <= cfg_data[3:0];
				end
			end
			if (accept) begin
				if (start) begin
					len_q <= packet_length;
					ack_q <= ack_byte;
					pseq_q <= seq_q;
					seq_q <= seq_next;
					count_q <= prod[18:16];
				end
				src_q <= src_n;
				dest_q <= dest_n;
				pkt_cnt_q <= last ? 8'd0 : cnt_n;
				if (send) begin
					fill_q <= '0;
					xor_q <= '0;
					fidx_q <= fidx_b + 3'd1;
					bank_q <= !bank_q;
				end else begin
					fill_q <= fill_n;
					xor_q <= xor_n;
					fidx_q <= fidx_b;
				end
			end
		end
	end

endmodule

/* sv/psf_desc_queue.sv */
module psf_desc_queue import psf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input frame_desc_t push_desc,
	output logic full,
	input logic pop,
	output frame_desc_t head,
	output logic empty
);

	frame_desc_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* sv/psf_back.sv */
module psf_back import psf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 23
) (
	input logic clk,
	input logic arst_n,
	input store_wr_t wr,
	input frame_desc_t head,
	input logic q_empty,
	output logic q_pop,
	output logic empty,
	input logic pop,
	output logic [7:0] frame_byte,
	output logic frame_end,
	output logic packet_end
);

	localparam int unsigned IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	localparam logic [FILL_W-1:0] POS_HEADER = 5'd0;
	localparam logic [FILL_W-1:0] POS_ACK = 5'd1;
	localparam logic [FILL_W-1:0] POS_CONTROL = 5'd2;
	localparam logic [FILL_W-1:0] POS_DEST = 5'd3;
	localparam logic [FILL_W-1:0] POS_SRC = 5'd4;
	localparam logic [FILL_W-1:0] POS_LEN = 5'd5;

	logic [7:0] store_q [2][MAX_PAYLOAD];

	logic [FILL_W-1:0] pos_q;
	logic rd_bank_q;
	logic valid_s1;
	logic pay_s1;
	logic fend_s1;
	logic pend_s1;
	logic [7:0] byte_s1;
	logic [7:0] rdata_s1;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_fend_q;
	logic out_pend_q;

	logic out_ready;
	logic adv1;
	logic issue;
	logic [FILL_W-1:0] off;
	logic [FILL_W-1:0] last_pos;
	logic [FILL_W-1:0] csum_pos;
	logic [7:0] byte_v;
	logic is_pay;
	logic is_last;

	assign out_ready = !out_valid_q || pop;
	assign adv1 = !valid_s1 || out_ready;
	assign issue = !q_empty && adv1;

	always_comb begin
		off = pos_q - HDR_BYTES;
		csum_pos = HDR_BYTES + head.fill;
		last_pos = head.fill + 5'(FRAME_OVERHEAD - 8'd1);
		is_last = (pos_q == last_pos);
		is_pay = 1'b0;
		byte_v = 8'd0;
		priority if (pos_q == POS_HEADER) begin
			byte_v = head.header;
		end else if (pos_q == POS_ACK) begin
			byte_v = head.ack;
		end else if (pos_q == POS_CONTROL) begin
			byte_v = head.control;
		end else if (pos_q == POS_DEST) begin
			byte_v = head.dest;
		end else if (pos_q == POS_SRC) begin
			byte_v = head.src;
		end else if (pos_q == POS_LEN) begin
			byte_v = head.len;
		end else if (pos_q < csum_pos) begin
			is_pay = 1'b1;
		end else if (pos_q == csum_pos) begin
			byte_v = head.csum;
		end else if (is_last) begin
			byte_v = FOOTER_BYTE;
		end else begin
			byte_v = 8'd0;
		end
	end

	assign q_pop = issue && is_last;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.bank][wr.off[IW-1:0]] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= store_q[rd_bank_q][off[IW-1:0]];
		end
		if (adv1) begin
			byte_s1 <= byte_v;
			pay_s1 <= is_pay;
			fend_s1 <= is_last;
			pend_s1 <= is_last && head.last;
		end
		if (out_ready) begin
			out_byte_q <= pay_s1 ? rdata_s1 : byte_s1;
			out_fend_q <= fend_s1;
			out_pend_q <= pend_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rd_bank_q <= 1'b0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (is_last) begin
					pos_q <= '0;
					rd_bank_q <= !rd_bank_q;
				end else begin
					pos_q <= pos_q + FILL_W'(1);
				end
			end
			if (adv1) begin
				valid_s1 <= issue;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign empty = !out_valid_q;
	assign frame_byte = out_byte_q;
	assign frame_end = out_fend_q;
	assign packet_end = out_pend_q;

endmodule

/* verif/tb_packet_segmenting_framer_core.sv */
`timescale 1ns / 1ps

module tb_packet_segmenting_framer_core;
	import psf_pkg::*;

	localparam int MAX_PL = 23;
	localparam int SEQ_WRAP = 15;
	localparam int SETTLE = 6;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] plen;
		logic [7:0] ack;
	} pkt_byte_t;

	typedef struct packed {
		logic [7:0] fbyte;
		logic fend;
		logic pend;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] data_byte = 8'd0;
	logic [7:0] packet_length = 8'd0;
	logic [7:0] ack_byte = 8'd0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] frame_byte;
	logic frame_end;
	logic packet_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_VERSION;
	logic [7:0] cfg_data = 8'd0;

	pkt_byte_t pkt_bytes_todo[$];
	frame_byte_t frame_bytes_due[$];

	// framer shadow state
	logic [7:0] pl_buf [MAX_PL];
	logic [4:0] p_fill;
	logic [7:0] p_cnt;
	logic [3:0] p_frm;
	logic [3:0] p_seq_next;
	logic [3:0] p_seq;
	logic [7:0] p_src;
	logic [7:0] p_dst;
	logic [7:0] p_len;
	logic [7:0] p_ack;
	logic [7:0] p_xor;
	logic [1:0] p_version;
	logic [3:0] p_ttl;

	int n_queued = 0;
	int n_taken = 0;
	int n_checked = 0;
	int n_pkts = 0;
	int n_frames = 0;
	int n_errors = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int quiet_cycles = 0;
	bit idle_en = 1'b1;

	packet_segmenting_framer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.packet_length(packet_length),
		.ack_byte(ack_byte),
		.empty(empty),
		.pop(pop),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.packet_end(packet_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic emit_frame(input logic last);
		int total;
		int count;
		logic [7:0] hdr;
		logic [7:0] flen;
		logic [7:0] csum;
		total = (p_len == 8'd0) ? 256 : int'(p_len);
		count = (total + MAX_PL - 1) / MAX_PL;
		hdr = {p_version, p_frm[2:0], 3'(count)};
		flen = 8'(p_fill) + FRAME_OVERHEAD;
		csum = hdr ^ p_src ^ p_dst ^ flen ^ FOOTER_BYTE ^ p_xor;
		frame_bytes_due.push_back('{hdr, 1'b0, 1'b0});
		frame_bytes_due.push_back('{p_ack, 1'b0, 1'b0});
		frame_bytes_due.push_back('{{p_ttl, p_seq}, 1'b0, 1'b0});
		frame_bytes_due.push_back('{p_dst, 1'b0, 1'b0});
		frame_bytes_due.push_back('{p_src, 1'b0, 1'b0});
		frame_bytes_due.push_back('{flen, 1'b0, 1'b0});
		for (int k = 0; k < int'(p_fill); k++)
			frame_bytes_due.push_back('{pl_buf[k], 1'b0, 1'b0});
		frame_bytes_due.push_back('{csum, 1'b0, 1'b0});
		frame_bytes_due.push_back('{8'd0, 1'b0, 1'b0});
		frame_bytes_due.push_back('{FOOTER_BYTE, 1'b1, last});
		p_fill = 5'd0;
		p_xor = 8'd0;
		p_frm = p_frm + 4'd1;
		n_frames++;
	endtask

	task automatic predict_frames(input pkt_byte_t it);
		logic last;
		if (p_cnt == 8'd0) begin
			p_len = it.plen;
			p_ack = it.ack;
			p_seq = p_seq_next;
			p_seq_next = (int'(p_seq_next) + 1 >= SEQ_WRAP) ? 4'd0 : p_seq_next + 4'd1;
			p_frm = 4'd0;
			p_fill = 5'd0;
			p_xor = 8'd0;
			p_src = 8'd0;
			p_dst = 8'd0;
			n_pkts++;
		end
		if (p_cnt == 8'd2)
			p_src = it.data;
		else if (p_cnt == 8'd3)
			p_dst = it.data;
		if (p_fill < MAX_PL)
			pl_buf[p_fill] = it.data;
		p_fill = p_fill + 5'd1;
		p_xor = p_xor ^ it.data;
		p_cnt = p_cnt + 8'd1;
		last = (p_cnt == p_len);
		if (last)
			p_cnt = 8'd0;
		if (last || p_fill >= MAX_PL)
			emit_frame(last);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_frames('{data_byte, packet_length, ack_byte});
				n_taken++;
			end
			if (!push || !full) begin
				if (send_gap > 0)
					send_gap--;
				else if (idle_en && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 19);
				if (send_gap == 0 && pkt_bytes_todo.size() > 0) begin
					pkt_byte_t nb;
					nb = pkt_bytes_todo.pop_front();
					data_byte <= nb.data;
					packet_length <= nb.plen;
					ack_byte <= nb.ack;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (frame_bytes_due.size() == 0) begin
					$error("unexpected frame byte %h", frame_byte);
					n_errors++;
				end else begin
					frame_byte_t want;
					want = frame_bytes_due.pop_front();
					if (frame_byte !== want.fbyte) begin
						$error("frame_byte: expected %h, got %h", want.fbyte, frame_byte);
						n_errors++;
					end
					if (frame_end !== want.fend) begin
						$error("frame_end: expected %b, got %b", want.fend, frame_end);
						n_errors++;
					end
					if (packet_end !== want.pend) begin
						$error("packet_end: expected %b, got %b", want.pend, packet_end);
						n_errors++;
					end
					n_checked++;
				end
			end
			if (recv_gap > 0)
				recv_gap--;
			else if (idle_en && $urandom_range(0, 9) == 0)
				recv_gap = $urandom_range(1, 19);
			pop <= (recv_gap == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("packet_segmenting_framer_core: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_VERSION)
			p_version = val[1:0];
		else if (idx == REG_TTL)
			p_ttl = val[3:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_packet(input int len, input int first, input int count, input bit extreme);
		pkt_byte_t nb;
		for (int i = first; i < first + count; i++) begin
			if (extreme)
				nb.data = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			else
				nb.data = 8'($urandom_range(0, 255));
			nb.plen = (i == 0) ? 8'(len) : 8'($urandom_range(0, 255));
			if (i != 0)
				nb.ack = 8'($urandom_range(0, 255));
			else if (extreme)
				nb.ack = (len % 2 == 1) ? 8'hFF : 8'h00;
			else
				nb.ack = 8'($urandom_range(0, 255));
			pkt_bytes_todo.push_back(nb);
			n_queued++;
		end
	endtask

	task automatic queue_short(input int n_pkt, input int max_len);
		int len;
		for (int j = 0; j < n_pkt; j++) begin
			len = $urandom_range(1, max_len);
			queue_packet(len, 0, len, 1'b0);
		end
	endtask

	task automatic wait_drain;
		do @(posedge clk); while (n_taken != n_queued || frame_bytes_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		p_fill = 5'd0;
		p_cnt = 8'd0;
		p_frm = 4'd0;
		p_seq_next = 4'd0;
		p_seq = 4'd0;
		p_src = 8'd0;
		p_dst = 8'd0;
		p_len = 8'd0;
		p_ack = 8'd0;
		p_xor = 8'd0;
		p_version = 2'd0;
		p_ttl = 4'd15;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, short packets and one that fills a frame exactly
		queue_packet(1, 0, 1, 1'b1);
		queue_packet(4, 0, 4, 1'b1);
		queue_packet(MAX_PL, 0, MAX_PL, 1'b1);
		wait_drain();

		// enough tiny packets to take the sequence number round its wrap
		write_reg(REG_VERSION, 8'd3);
		write_reg(REG_TTL, 8'd0);
		queue_short(12, 2);
		wait_drain();

		// length field zero means a full 256 byte packet
		write_reg(REG_VERSION, 8'($urandom_range(0, 255)));
		write_reg(REG_TTL, 8'hFF);
		queue_packet(0, 0, 100, 1'b0);
		// hold the sender mid-packet until all frames so far are out
		wait_drain();
		idle_en = 1'b0;
		queue_packet(0, 100, 156, 1'b0);
		wait_drain();
		repeat (20) @(posedge clk);

		$display("run covered %0d packet bytes in %0d packets over three register settings",
			n_taken, n_pkts);
		$display("%0d frames and %0d frame bytes compared, %0d errors",
			n_frames, n_checked, n_errors);
		if (n_errors == 0 && frame_bytes_due.size() == 0) begin
			$display("packet_segmenting_framer_core: match");
		end else begin
			$display("packet_segmenting_framer_core: mismatch");
		end
		$finish;
	end

endmodule
